>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// check on every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// check on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> hdl/pwgi_pkg.sv
// ----------------------------------------------------------------------------
// pwgi_pkg
// Shared types and constants of the gated-integral PID controller.
// ----------------------------------------------------------------------------
package pwgi_pkg;

    localparam int GAIN_FRAC_BITS_DFLT = 8;

    localparam int ERR_W   = 18;
    localparam int GAIN_W  = 16;
    localparam int GATE_W  = 17;
    localparam int LIMIT_W = 23;
    localparam int INTEG_W = 25;
    localparam int DERIV_W = ERR_W + 1;
    localparam int DRIVE_W = 8;
    localparam int CFG_W   = 23;
    localparam int IDX_W   = 3;

    localparam int PROD_P_W = ERR_W + GAIN_W;
    localparam int PROD_I_W = INTEG_W + GAIN_W;
    localparam int PROD_D_W = DERIV_W + GAIN_W;
    localparam int SUM_W    = PROD_I_W + 2;

    localparam int DRIVE_MAX = 127;
    localparam int DRIVE_MIN = -127;

    // register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_GAIN_P          = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_I          = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_D          = 3'd2;
    localparam logic [IDX_W-1:0] REG_INTEGRATE_BELOW = 3'd3;
    localparam logic [IDX_W-1:0] REG_INTEGRAL_LIMIT  = 3'd4;

    localparam logic signed [GAIN_W-1:0] GAIN_P_RST          = 16'sd192;
    localparam logic signed [GAIN_W-1:0] GAIN_I_RST          = 16'sd0;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RST          = 16'sd0;
    localparam logic [GATE_W-1:0]        INTEGRATE_BELOW_RST = 17'd92160;
    localparam logic [LIMIT_W-1:0]       INTEGRAL_LIMIT_RST  = 23'd8388607;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [GATE_W-1:0]        integrate_below;
        logic [LIMIT_W-1:0]       integral_limit;
    } t_cfg;

endpackage

>>> hdl/pwgi_cfg_regs.sv
// ----------------------------------------------------------------------------
// pwgi_cfg_regs
// Configuration register file: gains, integration gate and integral cap.
// ----------------------------------------------------------------------------
module pwgi_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [pwgi_pkg::IDX_W-1:0]       i_cfg_index,
    input  logic [pwgi_pkg::CFG_W-1:0]       i_cfg_data,
    output pwgi_pkg::t_cfg                   o_cfg
);

    pwgi_pkg::t_cfg r_cfg;
    pwgi_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                pwgi_pkg::REG_GAIN_P: begin
                    n_cfg.gain_p = i_cfg_data[pwgi_pkg::GAIN_W-1:0];
                end
                pwgi_pkg::REG_GAIN_I: begin
                    n_cfg.gain_i = i_cfg_data[pwgi_pkg::GAIN_W-1:0];
                end
                pwgi_pkg::REG_GAIN_D: begin
                    n_cfg.gain_d = i_cfg_data[pwgi_pkg::GAIN_W-1:0];
                end
                pwgi_pkg::REG_INTEGRATE_BELOW: begin
                    n_cfg.integrate_below = i_cfg_data[pwgi_pkg::GATE_W-1:0];
                end
                pwgi_pkg::REG_INTEGRAL_LIMIT: begin
                    n_cfg.integral_limit = i_cfg_data[pwgi_pkg::LIMIT_W-1:0];
                end
                default: begin
                    // drop writes to unused indexes
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p          <= pwgi_pkg::GAIN_P_RST;
            r_cfg.gain_i          <= pwgi_pkg::GAIN_I_RST;
            r_cfg.gain_d          <= pwgi_pkg::GAIN_D_RST;
            r_cfg.integrate_below <= pwgi_pkg::INTEGRATE_BELOW_RST;
            r_cfg.integral_limit  <= pwgi_pkg::INTEGRAL_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/pwgi_integ.sv
// ----------------------------------------------------------------------------
// pwgi_integ
// Gated integral update with one-sided clamp, and error difference.
// ----------------------------------------------------------------------------
module pwgi_integ (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_load,
    input  logic signed [pwgi_pkg::ERR_W-1:0]      i_err,
    input  pwgi_pkg::t_cfg                         i_cfg,
    output logic signed [pwgi_pkg::ERR_W-1:0]      o_err,
    output logic signed [pwgi_pkg::INTEG_W-1:0]    o_integ,
    output logic signed [pwgi_pkg::DERIV_W-1:0]    o_deriv
);

    localparam int ACC_W = pwgi_pkg::INTEG_W + 1;

    localparam logic signed [ACC_W-1:0] ACC_MAX =
        ACC_W'((64'sd1 <<< (pwgi_pkg::INTEG_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] ACC_MIN =
        ACC_W'(-(64'sd1 <<< (pwgi_pkg::INTEG_W - 1)));

    logic signed [pwgi_pkg::INTEG_W-1:0] r_integ;
    logic signed [pwgi_pkg::ERR_W-1:0]   r_last_err;
    logic signed [pwgi_pkg::ERR_W-1:0]   r_err;
    logic signed [pwgi_pkg::DERIV_W-1:0] r_deriv;

    logic [pwgi_pkg::ERR_W-1:0]          mag;
    logic                                gate;
    logic                                err_pos;
    logic signed [ACC_W-1:0]             lim;
    logic signed [ACC_W-1:0]             acc;
    logic signed [ACC_W-1:0]             clamped;
    logic signed [pwgi_pkg::INTEG_W-1:0] n_integ;
    logic signed [pwgi_pkg::DERIV_W-1:0] n_deriv;

    always_comb begin
        mag     = i_err[pwgi_pkg::ERR_W-1] ? (~i_err + 1'b1) : i_err;
        gate    = mag < {1'b0, i_cfg.integrate_below};
        err_pos = !i_err[pwgi_pkg::ERR_W-1] && (i_err != '0);
        lim     = ACC_W'({1'b0, i_cfg.integral_limit});
        acc     = ACC_W'(r_integ) + (gate ? ACC_W'(i_err) : '0);

        // clamp only on the side picked by the error sign
        clamped = acc;
        if (err_pos) begin
            if (acc > lim) begin
                clamped = lim;
            end
        end else begin
            if (acc < -lim) begin
                clamped = -lim;
            end
        end

        priority if (clamped > ACC_MAX) begin
            n_integ = pwgi_pkg::INTEG_W'(ACC_MAX);
        end else if (clamped < ACC_MIN) begin
            n_integ = pwgi_pkg::INTEG_W'(ACC_MIN);
        end else begin
            n_integ = clamped[pwgi_pkg::INTEG_W-1:0];
        end

        n_deriv = pwgi_pkg::DERIV_W'(i_err) - pwgi_pkg::DERIV_W'(r_last_err);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_last_err <= '0;
        end else if (i_load) begin
            r_integ    <= n_integ;
            r_last_err <= i_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_err   <= i_err;
            r_deriv <= n_deriv;
        end
    end

    // the accumulator itself is this stage's integral term
    assign o_err   = r_err;
    assign o_integ = r_integ;
    assign o_deriv = r_deriv;

endmodule

>>> hdl/pwgi_mac.sv
// ----------------------------------------------------------------------------
// pwgi_mac
// Three gain products, their sum, floor shift and drive saturation.
// ----------------------------------------------------------------------------
module pwgi_mac #(
    parameter int GAIN_FRAC_BITS = pwgi_pkg::GAIN_FRAC_BITS_DFLT
) (
    input  logic                                   i_clk,
    input  logic                                   i_load_prod,
    input  logic                                   i_load_drive,
    input  logic signed [pwgi_pkg::ERR_W-1:0]      i_err,
    input  logic signed [pwgi_pkg::INTEG_W-1:0]    i_integ,
    input  logic signed [pwgi_pkg::DERIV_W-1:0]    i_deriv,
    input  pwgi_pkg::t_cfg                         i_cfg,
    output logic signed [pwgi_pkg::DRIVE_W-1:0]    o_drive
);

    localparam int SHIFT = 8 + GAIN_FRAC_BITS;
    localparam int SUM_W = pwgi_pkg::SUM_W;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(pwgi_pkg::DRIVE_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(pwgi_pkg::DRIVE_MIN);

    logic signed [pwgi_pkg::PROD_P_W-1:0] r_prod_p;
    logic signed [pwgi_pkg::PROD_I_W-1:0] r_prod_i;
    logic signed [pwgi_pkg::PROD_D_W-1:0] r_prod_d;
    logic signed [pwgi_pkg::DRIVE_W-1:0]  r_drive;

    logic signed [pwgi_pkg::PROD_P_W-1:0] n_prod_p;
    logic signed [pwgi_pkg::PROD_I_W-1:0] n_prod_i;
    logic signed [pwgi_pkg::PROD_D_W-1:0] n_prod_d;
    logic signed [SUM_W-1:0]              sum;
    logic signed [SUM_W-1:0]              shifted;
    logic signed [pwgi_pkg::DRIVE_W-1:0]  n_drive;

    always_comb begin
        n_prod_p = i_err * i_cfg.gain_p;
        n_prod_i = i_integ * i_cfg.gain_i;
        n_prod_d = i_deriv * i_cfg.gain_d;
    end

    always_comb begin
        sum     = SUM_W'(r_prod_p) + SUM_W'(r_prod_i) + SUM_W'(r_prod_d);
        // arithmetic shift rounds toward minus infinity
        shifted = sum >>> SHIFT;
        priority if (shifted > SAT_HI) begin
            n_drive = pwgi_pkg::DRIVE_W'(SAT_HI);
        end else if (shifted < SAT_LO) begin
            n_drive = pwgi_pkg::DRIVE_W'(SAT_LO);
        end else begin
            n_drive = shifted[pwgi_pkg::DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_prod) begin
            r_prod_p <= n_prod_p;
            r_prod_i <= n_prod_i;
            r_prod_d <= n_prod_d;
        end
        if (i_load_drive) begin
            r_drive <= n_drive;
        end
    end

    assign o_drive = r_drive;

endmodule

>>> hdl/pid_with_gated_integral_top.sv
// ----------------------------------------------------------------------------
// pid_with_gated_integral_top
// PID position controller with gated, clamped integral and saturated drive.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata[17:0] position_error (signed Q.8 degrees)
//  m_axis    out        tdata[7:0]  drive (signed, -127..127)
//  cfg       in         index 0..4: gain_p, gain_i, gain_d, integrate_below,
//                       integral_limit
//
//  One sample per cycle while the output is not stalled; the result passes
//  through four registers: input, integral update, gain products,
//  sum and saturate.
//  The integral update is the only loop; it closes through its own accumulator register.
//  Each stage holds its item while the next stage is full and not emptying, so a
//  stalled output still lets upstream stages fill.
//  Reset clears the accumulator and previous error; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pid_with_gated_integral_top #(
    parameter int GAIN_FRAC_BITS = pwgi_pkg::GAIN_FRAC_BITS_DFLT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [23:0]                     s_axis_tdata,  // [17:0] position_error
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,  // [7:0] drive
    input  logic                            i_cfg_wr_en,
    input  logic [pwgi_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [pwgi_pkg::CFG_W-1:0]      i_cfg_data
);

    pwgi_pkg::t_cfg cfg;

    logic r_v0, r_v1, r_v2, r_v3;
    logic n_v0, n_v1, n_v2, n_v3;
    logic free0, free1, free2, free3;
    logic mv0, mv1, mv2;
    logic in_xfer, out_xfer;

    logic signed [pwgi_pkg::ERR_W-1:0]   r_err0;
    logic signed [pwgi_pkg::ERR_W-1:0]   err1;
    logic signed [pwgi_pkg::INTEG_W-1:0] integ1;
    logic signed [pwgi_pkg::DERIV_W-1:0] deriv1;
    logic signed [pwgi_pkg::DRIVE_W-1:0] drive;

    // stage occupancy: a stage takes a new item when empty or emptying
    always_comb begin
        out_xfer = r_v3 && m_axis_tready;
        free3    = !r_v3 || m_axis_tready;
        mv2      = r_v2 && free3;
        free2    = !r_v2 || free3;
        mv1      = r_v1 && free2;
        free1    = !r_v1 || free2;
        mv0      = r_v0 && free1;
        free0    = !r_v0 || free1;
        in_xfer  = s_axis_tvalid && free0;

        n_v0 = in_xfer || (r_v0 && !mv0);
        n_v1 = mv0 || (r_v1 && !mv1);
        n_v2 = mv1 || (r_v2 && !mv2);
        n_v3 = mv2 || (r_v3 && !out_xfer);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_err0 <= s_axis_tdata[pwgi_pkg::ERR_W-1:0];
        end
    end

    pwgi_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pwgi_integ u_integ (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (mv0),
        .i_err   (r_err0),
        .i_cfg   (cfg),
        .o_err   (err1),
        .o_integ (integ1),
        .o_deriv (deriv1)
    );

    pwgi_mac #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_mac (
        .i_clk        (i_clk),
        .i_load_prod  (mv1),
        .i_load_drive (mv2),
        .i_err        (err1),
        .i_integ      (integ1),
        .i_deriv      (deriv1),
        .i_cfg        (cfg),
        .o_drive      (drive)
    );

    assign s_axis_tready = free0;
    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = drive;

    `ASSERT_CLK(a_drive_in_range, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tdata != 8'h80))
    `ASSERT_CLK(a_out_held, i_clk, i_rst_n, (r_v3 && !m_axis_tready) |=> r_v3)
    `ASSERT_CLK(a_in_captured, i_clk, i_rst_n, in_xfer |=> r_v0)
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!m_axis_tvalid && !r_v0 && !r_v1))

endmodule

>>> verif/pid_with_gated_integral_checker.sv
// ----------------------------------------------------------------------------
// pid_with_gated_integral_checker
// Watches the error, drive and register channels of the PID controller,
// predicts every drive command from its own copy of the gains, the gate,
// the limit and the loop state, and compares each drive transfer in order.
// ----------------------------------------------------------------------------
module pid_with_gated_integral_checker
    import pwgi_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DFLT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [23:0]        s_axis_tdata,   // [17:0] position_error
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [7:0]         m_axis_tdata,   // [7:0] drive
    input  logic               i_cfg_wr_en,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int ACC_HIGH = 16777215;
    localparam int ACC_LOW  = -16777216;

    t_cfg                       cfg;
    logic signed [INTEG_W-1:0]  integral_acc;
    logic signed [ERR_W-1:0]    prev_error;
    logic [DRIVE_W-1:0]         expected_drives[$];
    logic [DRIVE_W-1:0]         exp_drive;
    int                         fails = 0;

    // Advance the loop state by one error sample and return the drive.
    function automatic logic [DRIVE_W-1:0] predict_drive(input logic signed [ERR_W-1:0] err);
        logic [ERR_W-1:0]           mag;
        logic signed [INTEG_W:0]    acc;
        logic signed [INTEG_W:0]    lim;
        logic signed [DERIV_W-1:0]  deriv;
        logic signed [63:0]         total;
        logic signed [63:0]         scaled;
        mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        acc = integral_acc;
        if (mag < cfg.integrate_below)
            acc = acc + err;
        lim = $signed({2'b00, cfg.integral_limit});
        // clamp only on the side picked by the sign; zero counts as negative
        if (err > 0) begin
            if (acc > lim)
                acc = lim;
        end else begin
            if (acc < -lim)
                acc = -lim;
        end
        if (acc > ACC_HIGH)
            acc = ACC_HIGH;
        if (acc < ACC_LOW)
            acc = ACC_LOW;
        integral_acc = acc[INTEG_W-1:0];
        deriv = err - prev_error;
        prev_error = err;
        total = err * cfg.gain_p + integral_acc * cfg.gain_i + deriv * cfg.gain_d;
        scaled = total >>> (8 + GAIN_FRAC_BITS);
        if (scaled > DRIVE_MAX)
            scaled = DRIVE_MAX;
        if (scaled < DRIVE_MIN)
            scaled = DRIVE_MIN;
        return scaled[DRIVE_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.gain_p          = GAIN_P_RST;
            cfg.gain_i          = GAIN_I_RST;
            cfg.gain_d          = GAIN_D_RST;
            cfg.integrate_below = INTEGRATE_BELOW_RST;
            cfg.integral_limit  = INTEGRAL_LIMIT_RST;
            integral_acc        = '0;
            prev_error          = '0;
            expected_drives.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_drives.size() == 0) begin
                    $display("%0t: drive transfer with none expected, actual %0d",
                             $time, $signed(m_axis_tdata));
                    fails++;
                end else begin
                    exp_drive = expected_drives.pop_front();
                    if (m_axis_tdata !== exp_drive) begin
                        $display("%0t: drive mismatch, expected %0d, actual %0d",
                                 $time, $signed(exp_drive), $signed(m_axis_tdata));
                        fails++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_drives.push_back(predict_drive(s_axis_tdata[ERR_W-1:0]));
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_GAIN_P:          cfg.gain_p          = i_cfg_data[GAIN_W-1:0];
                    REG_GAIN_I:          cfg.gain_i          = i_cfg_data[GAIN_W-1:0];
                    REG_GAIN_D:          cfg.gain_d          = i_cfg_data[GAIN_W-1:0];
                    REG_INTEGRATE_BELOW: cfg.integrate_below = i_cfg_data[GATE_W-1:0];
                    REG_INTEGRAL_LIMIT:  cfg.integral_limit  = i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_drives.size();
    end

endmodule

>>> verif/pid_with_gated_integral_top_tb.sv
// ----------------------------------------------------------------------------
// pid_with_gated_integral_top_tb
// Drives position error samples and register writes into the PID controller:
// a directed part for the gate edges, clamp sides, limit changes and gain
// extremes, then random error sequences under several idle and stall mixes.
// ----------------------------------------------------------------------------
module pid_with_gated_integral_top_tb;
    import pwgi_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 12;
    localparam int ITEMS_PER_BLOCK = 106;
    localparam int BLOCKS_PER_PASS = 4;
    localparam int ERR_SPAN        = 92160;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [23:0]        s_axis_tdata = '0;   // [17:0] position_error
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [7:0]         m_axis_tdata;        // [7:0] drive
    logic               i_cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]   i_cfg_data = '0;

    int fail_count;
    int pending;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int idle_cycles = 0;
    int walk_err = 0;
    int pick;
    int src_pct[4]  = '{0, 86, 0, 8};
    int sink_pct[4] = '{0, 0, 86, 8};

    int gate_errors[10]  = '{0, 1, -1, 92159, 92160, -92160, 131071, -131072, -342, 341};
    int clamp_errors[5]  = '{999, 999, 1000, 999, 0};
    int lower_errors[3]  = '{-5, 0, 7};
    int strong_errors[4] = '{92160, -92160, 131071, -131072};

    pid_with_gated_integral_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    pid_with_gated_integral_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("pid_with_gated_integral_top regression: fail");
            $finish;
        end
    end

    // Hold the sample until its transfer; keep tvalid high for a following item.
    task automatic send_error(input logic signed [ERR_W-1:0] err);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, err};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drop the stream and let the pipeline run dry before touching registers.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic signed [GAIN_W-1:0] gp,
                                input logic signed [GAIN_W-1:0] gi,
                                input logic signed [GAIN_W-1:0] gd,
                                input logic [GATE_W-1:0]        gate,
                                input logic [LIMIT_W-1:0]       lim);
        // unused upper data bits carry noise; the block must drop them
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_GAIN_P;
        i_cfg_data  <= {7'($urandom), gp};
        @(posedge i_clk);
        i_cfg_index <= REG_GAIN_I;
        i_cfg_data  <= {7'($urandom), gi};
        @(posedge i_clk);
        i_cfg_index <= REG_GAIN_D;
        i_cfg_data  <= {7'($urandom), gd};
        @(posedge i_clk);
        i_cfg_index <= REG_INTEGRATE_BELOW;
        i_cfg_data  <= {6'($urandom), gate};
        @(posedge i_clk);
        i_cfg_index <= REG_INTEGRAL_LIMIT;
        i_cfg_data  <= lim;
        @(posedge i_clk);
        // an index past the register list must be ignored
        i_cfg_index <= REG_INTEGRAL_LIMIT + IDX_W'($urandom_range(1, 3));
        i_cfg_data  <= CFG_W'($urandom);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic random_config();
        logic signed [GAIN_W-1:0] gains[3];
        logic [GATE_W-1:0]        gate;
        logic [LIMIT_W-1:0]       lim;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 6))
                0:       gains[k] = 16'sh8000;
                1:       gains[k] = 16'sh7fff;
                2:       gains[k] = 16'sd0;
                3:       gains[k] = GAIN_W'($urandom);
                default: gains[k] = GAIN_W'($urandom_range(0, 511)) - 16'sd256;
            endcase
        end
        case ($urandom_range(0, 4))
            0:       gate = '0;
            1:       gate = 17'd92160;
            2:       gate = '1;
            3:       gate = GATE_W'($urandom_range(0, 4000));
            default: gate = GATE_W'($urandom_range(0, ERR_SPAN));
        endcase
        case ($urandom_range(0, 4))
            0:       lim = '0;
            1:       lim = '1;
            2:       lim = LIMIT_W'($urandom);
            default: lim = LIMIT_W'($urandom_range(0, 5000));
        endcase
        write_config(gains[0], gains[1], gains[2], gate, lim);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: gate edges, floor rounding, out-of-range errors
        foreach (gate_errors[k])
            send_error(ERR_W'(gate_errors[k]));
        wait_idle();

        // integral alone: fill to the cap, sample at the gate, zero error
        write_config(16'sd0, 16'sd256, 16'sd0, 17'd1000, 23'd1500);
        foreach (clamp_errors[k])
            send_error(ERR_W'(clamp_errors[k]));
        wait_idle();

        // limit lowered under the accumulator
        write_config(16'sd0, 16'sd256, 16'sd0, 17'd1000, 23'd200);
        foreach (lower_errors[k])
            send_error(ERR_W'(lower_errors[k]));
        wait_idle();

        // gain extremes drive the output into both rails
        write_config(16'sh8000, 16'sh7fff, 16'sh8000, '1, '1);
        foreach (strong_errors[k])
            send_error(ERR_W'(strong_errors[k]));
        wait_idle();

        for (int p = 0; p < 4; p++) begin
            src_idle_pct   = src_pct[p];
            sink_stall_pct = sink_pct[p];
            for (int b = 0; b < BLOCKS_PER_PASS; b++) begin
                random_config();
                walk_err = int'($urandom_range(0, 2 * ERR_SPAN)) - ERR_SPAN;
                for (int n = 0; n < ITEMS_PER_BLOCK; n++) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 5) begin
                        // slowly moving error, as from a real position loop
                        walk_err = walk_err + int'($urandom_range(0, 1024)) - 512;
                        if (walk_err > ERR_SPAN)
                            walk_err = ERR_SPAN;
                        if (walk_err < -ERR_SPAN)
                            walk_err = -ERR_SPAN;
                    end else if (pick < 8) begin
                        walk_err = int'($urandom_range(0, 2 * ERR_SPAN)) - ERR_SPAN;
                    end else if (pick < 9) begin
                        walk_err = int'($urandom_range(0, 600)) - 300;
                    end else begin
                        walk_err = int'($signed(ERR_W'($urandom)));
                    end
                    send_error(ERR_W'(walk_err));
                end
                wait_idle();
            end
        end

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("pid_with_gated_integral_top regression: pass");
        else
            $display("pid_with_gated_integral_top regression: fail");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/pwgi_pkg.sv
hdl/pwgi_cfg_regs.sv
hdl/pwgi_integ.sv
hdl/pwgi_mac.sv
hdl/pid_with_gated_integral_top.sv
verif/pid_with_gated_integral_checker.sv
verif/pid_with_gated_integral_top_tb.sv
